### sv/sha256_stream_hasher_defines.svh
// Assertion helpers shared by the hasher top level.
`ifndef SHA256_STREAM_HASHER_DEFINES_SVH
`define SHA256_STREAM_HASHER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SHA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define SHA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### sv/sha256_pkg.sv
package sha256_pkg;

  localparam int unsigned LEN_POS      = 56;
  localparam int unsigned DIGEST_WORDS = 8;
  localparam logic [7:0]  PAD_MARK     = 8'h80;
  localparam logic [5:0]  LAST_BYTE    = 6'd63;
  localparam logic [5:0]  LAST_ROUND   = 6'd63;
  localparam logic [5:0]  LAST_LOAD    = 6'd15;
  localparam logic [2:0]  LAST_DIGEST  = 3'd7;

  typedef struct packed {
    logic        last_blk;  // final word of the message's last block
    logic [31:0] word;
  } q_entry_t;

  typedef enum logic [0:0] {
    F_COLLECT,
    F_PAD
  } front_state_t;

  typedef enum logic [1:0] {
    B_LOAD,
    B_EXPAND,
    B_ADD,
    B_EMIT
  } core_state_t;

  function automatic logic [31:0] init_hash(input logic [2:0] idx);
    logic [31:0] v;
    unique case (idx)
      3'd0: v = 32'h6a09e667;
      3'd1: v = 32'hbb67ae85;
      3'd2: v = 32'h3c6ef372;
      3'd3: v = 32'ha54ff53a;
      3'd4: v = 32'h510e527f;
      3'd5: v = 32'h9b05688c;
      3'd6: v = 32'h1f83d9ab;
      default: v = 32'h5be0cd19;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] r);
    logic [31:0] v;
    unique case (r)
      6'd0:  v = 32'h428A2F98; 6'd1:  v = 32'h71374491;
      6'd2:  v = 32'hB5C0FBCF; 6'd3:  v = 32'hE9B5DBA5;
      6'd4:  v = 32'h3956C25B; 6'd5:  v = 32'h59F111F1;
      6'd6:  v = 32'h923F82A4; 6'd7:  v = 32'hAB1C5ED5;
      6'd8:  v = 32'hD807AA98; 6'd9:  v = 32'h12835B01;
      6'd10: v = 32'h243185BE; 6'd11: v = 32'h550C7DC3;
      6'd12: v = 32'h72BE5D74; 6'd13: v = 32'h80DEB1FE;
      6'd14: v = 32'h9BDC06A7; 6'd15: v = 32'hC19BF174;
      6'd16: v = 32'hE49B69C1; 6'd17: v = 32'hEFBE4786;
      6'd18: v = 32'h0FC19DC6; 6'd19: v = 32'h240CA1CC;
      6'd20: v = 32'h2DE92C6F; 6'd21: v = 32'h4A7484AA;
      6'd22: v = 32'h5CB0A9DC; 6'd23: v = 32'h76F988DA;
      6'd24: v = 32'h983E5152; 6'd25: v = 32'hA831C66D;
      6'd26: v = 32'hB00327C8; 6'd27: v = 32'hBF597FC7;
      6'd28: v = 32'hC6E00BF3; 6'd29: v = 32'hD5A79147;
      6'd30: v = 32'h06CA6351; 6'd31: v = 32'h14292967;
      6'd32: v = 32'h27B70A85; 6'd33: v = 32'h2E1B2138;
      6'd34: v = 32'h4D2C6DFC; 6'd35: v = 32'h53380D13;
      6'd36: v = 32'h650A7354; 6'd37: v = 32'h766A0ABB;
      6'd38: v = 32'h81C2C92E; 6'd39: v = 32'h92722C85;
      6'd40: v = 32'hA2BFE8A1; 6'd41: v = 32'hA81A664B;
      6'd42: v = 32'hC24B8B70; 6'd43: v = 32'hC76C51A3;
      6'd44: v = 32'hD192E819; 6'd45: v = 32'hD6990624;
      6'd46: v = 32'hF40E3585; 6'd47: v = 32'h106AA070;
      6'd48: v = 32'h19A4C116; 6'd49: v = 32'h1E376C08;
      6'd50: v = 32'h2748774C; 6'd51: v = 32'h34B0BCB5;
      6'd52: v = 32'h391C0CB3; 6'd53: v = 32'h4ED8AA4A;
      6'd54: v = 32'h5B9CCA4F; 6'd55: v = 32'h682E6FF3;
      6'd56: v = 32'h748F82EE; 6'd57: v = 32'h78A5636F;
      6'd58: v = 32'h84C87814; 6'd59: v = 32'h8CC70208;
      6'd60: v = 32'h90BEFFFA; 6'd61: v = 32'hA4506CEB;
      6'd62: v = 32'hBEF9A3F7;
      default: v = 32'hC67178F2;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

endpackage

### sv/sha256_stream_hasher.sv
// Input: one byte per cycle while collecting and the queue has room; per block the core
// runs 64 rounds plus one chaining add and takes no words of the next block until then.
// End of message: after the last transaction the front pads with 64 - fill bytes (64 more
// when the length no longer fits); the first digest word follows the last packed word by
// one pop, 48 rounds and one add, later while earlier blocks are still queued.
// Reset: synchronous, active low; clears all control and reloads the initial hash value.
`include "sha256_stream_hasher_defines.svh"

module sha256_stream_hasher #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] byte_present
  input  logic        in_tlast,   // end_of_message
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] digest_word
  output logic [2:0]  out_tuser,  // [2:0] word_index
  output logic        out_tlast   // last_word
);
  import sha256_pkg::*;

  // Front side: take one transaction per cycle while the queue has room, pack bytes into
  // words and, at end of message, run the padding and length bytes through the same packer.
  // Back side: pull sixteen words per block from the queue and compress.
  q_entry_t push_data, pop_data;
  logic     q_push, q_pop, q_full, q_empty;

  sha256_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .q_push    (q_push),
    .q_data    (push_data),
    .q_full    (q_full)
  );

  // Word queue: lets the front keep collecting while the core runs rounds 16..63
  // or waits for the digest to drain.
  sha256_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_data),
    .pop       (q_pop),
    .pop_data  (pop_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  sha256_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .q_data     (pop_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // The front must never push into a full queue, nor the core pop an empty one.
  `SHA_ASSERT_NOW(a_no_overflow, q_push, !q_full, "word pushed into full queue")
  `SHA_ASSERT_NOW(a_no_underflow, q_pop, !q_empty, "word popped from empty queue")
  // After the last digest word is taken the core returns to loading blocks.
  `SHA_ASSERT_NEXT(a_digest_ends, out_tvalid && out_tready && out_tlast, !out_tvalid,
                   "digest output continued past last word")

endmodule

### sv/sha256_front.sv
module sha256_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [7:0]           in_tdata,
  input  logic                 in_tuser,
  input  logic                 in_tlast,
  output logic                 q_push,
  output sha256_pkg::q_entry_t q_data,
  input  logic                 q_full
);
  import sha256_pkg::*;

  front_state_t state_r, state_nxt;
  logic [5:0]   fill_r, fill_nxt;
  logic [23:0]  word_r, word_nxt;
  logic [63:0]  bits_r, bits_nxt;
  logic         first_r, first_nxt;
  logic         len_phase_r, len_phase_nxt;
  logic         byte_push;
  logic [7:0]   byte_val;
  logic         done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= F_COLLECT;
      fill_r      <= '0;
      bits_r      <= '0;
      first_r     <= 1'b0;
      len_phase_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      bits_r      <= bits_nxt;
      first_r     <= first_nxt;
      len_phase_r <= len_phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    bits_nxt      = bits_r;
    first_nxt     = first_r;
    len_phase_nxt = len_phase_r;
    in_tready     = 1'b0;
    byte_push     = 1'b0;
    byte_val      = 8'h00;
    done          = 1'b0;
    unique case (state_r)
      F_COLLECT: begin
        in_tready = !q_full;
        if (in_tvalid && !q_full) begin
          if (in_tuser) begin
            byte_push = 1'b1;
            byte_val  = in_tdata;
            bits_nxt  = bits_r + 64'd8;
          end
          if (in_tlast) begin
            state_nxt = F_PAD;
            first_nxt = 1'b1;
          end
        end
      end
      F_PAD: begin
        if (!q_full) begin
          byte_push = 1'b1;
          if (first_r) begin
            byte_val  = PAD_MARK;
            first_nxt = 1'b0;
            if (fill_r < 6'(LEN_POS)) len_phase_nxt = 1'b1;
          end else if (len_phase_r && fill_r >= 6'(LEN_POS)) begin
            // length goes out most significant byte first
            byte_val = bits_r[{~fill_r[2:0], 3'b000} +: 8];
          end
          if (fill_r == LAST_BYTE) begin
            if (len_phase_r && !first_r) begin
              done          = 1'b1;
              state_nxt     = F_COLLECT;
              bits_nxt      = '0;
              len_phase_nxt = 1'b0;
            end else begin
              len_phase_nxt = 1'b1;
            end
          end
        end
      end
      default: state_nxt = F_COLLECT;
    endcase
  end

  // byte packer: four bytes to a big-endian word
  always_comb begin
    fill_nxt        = fill_r;
    word_nxt        = word_r;
    q_push          = 1'b0;
    q_data.word     = {word_r, byte_val};
    q_data.last_blk = done;
    if (byte_push) begin
      fill_nxt = fill_r + 6'd1;
      if (fill_r[1:0] == 2'b11) begin
        q_push = 1'b1;
      end else begin
        word_nxt = {word_r[15:0], byte_val};
      end
    end
  end

endmodule

### sv/sha256_queue.sv
module sha256_queue #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  sha256_pkg::q_entry_t push_data,
  input  logic                 pop,
  output sha256_pkg::q_entry_t pop_data,
  output logic                 full,
  output logic                 empty
);
  import sha256_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  q_entry_t         mem [DEPTH];
  q_entry_t         head_r;
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [PTR_W-1:0] rd_ptr_nxt;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign full       = (count_r == FULL_CNT);
  assign empty      = (count_r == '0);
  assign do_push    = push && !full;
  assign do_pop     = pop && !empty;
  assign rd_ptr_nxt = !do_pop ? rd_ptr_r :
                      (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
  assign pop_data   = head_r;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
    // hold the head entry in a register; a word landing in the empty head slot bypasses
    if (do_push && (wr_ptr_r == rd_ptr_nxt)) begin
      head_r <= push_data;
    end else begin
      head_r <= mem[rd_ptr_nxt];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
      rd_ptr_r <= rd_ptr_nxt;
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + CNT_W'(1);
        2'b01:   count_r <= count_r - CNT_W'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

### sv/sha256_core.sv
module sha256_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_empty,
  output logic                 q_pop,
  input  sha256_pkg::q_entry_t q_data,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [31:0]          out_tdata,
  output logic [2:0]           out_tuser,
  output logic                 out_tlast
);
  import sha256_pkg::*;

  core_state_t state_r, state_nxt;
  logic [5:0]  rnd_r, rnd_nxt;
  logic        last_r, last_nxt;
  logic [31:0] chain_r [8];
  logic [31:0] chain_nxt [8];
  logic [31:0] g_r [8];
  logic [31:0] g_nxt [8];
  logic [31:0] w_r [16];
  logic [31:0] src [8];
  logic [31:0] w_new, t1, t2;
  logic        step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_LOAD;
      rnd_r   <= '0;
      last_r  <= 1'b0;
      for (int i = 0; i < 8; i++) chain_r[i] <= init_hash(3'(i));
    end else begin
      state_r <= state_nxt;
      rnd_r   <= rnd_nxt;
      last_r  <= last_nxt;
      chain_r <= chain_nxt;
    end
  end

  // working registers and schedule window
  always_ff @(posedge clk) begin
    if (step) begin
      g_r <= g_nxt;
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
      w_r[15] <= w_new;
    end
  end

  // round 0 starts from the chaining value
  always_comb begin
    for (int i = 0; i < 8; i++) src[i] = (rnd_r == '0) ? chain_r[i] : g_r[i];
  end

  always_comb begin
    if (state_r == B_LOAD) begin
      w_new = q_data.word;
    end else begin
      w_new = small_sigma1(w_r[14]) + w_r[9] + small_sigma0(w_r[1]) + w_r[0];
    end
    t1 = src[7] + big_sigma1(src[4]) + ((src[4] & src[5]) ^ (~src[4] & src[6]))
         + round_k(rnd_r) + w_new;
    t2 = big_sigma0(src[0]) + ((src[0] & src[1]) ^ (src[0] & src[2]) ^ (src[1] & src[2]));
    g_nxt[0] = t1 + t2;
    g_nxt[1] = src[0];
    g_nxt[2] = src[1];
    g_nxt[3] = src[2];
    g_nxt[4] = src[3] + t1;
    g_nxt[5] = src[4];
    g_nxt[6] = src[5];
    g_nxt[7] = src[6];
  end

  always_comb begin
    state_nxt  = state_r;
    rnd_nxt    = rnd_r;
    last_nxt   = last_r;
    chain_nxt  = chain_r;
    q_pop      = 1'b0;
    step       = 1'b0;
    out_tvalid = 1'b0;
    out_tdata  = chain_r[rnd_r[2:0]];
    out_tuser  = rnd_r[2:0];
    out_tlast  = (rnd_r[2:0] == LAST_DIGEST);
    unique case (state_r)
      B_LOAD: begin
        if (!q_empty) begin
          q_pop   = 1'b1;
          step    = 1'b1;
          rnd_nxt = rnd_r + 6'd1;
          if (rnd_r == LAST_LOAD) begin
            last_nxt  = q_data.last_blk;
            state_nxt = B_EXPAND;
          end
        end
      end
      B_EXPAND: begin
        step    = 1'b1;
        rnd_nxt = rnd_r + 6'd1;
        if (rnd_r == LAST_ROUND) state_nxt = B_ADD;
      end
      B_ADD: begin
        for (int i = 0; i < 8; i++) chain_nxt[i] = chain_r[i] + g_r[i];
        state_nxt = last_r ? B_EMIT : B_LOAD;
      end
      B_EMIT: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          rnd_nxt = rnd_r + 6'd1;
          if (rnd_r[2:0] == LAST_DIGEST) begin
            rnd_nxt   = '0;
            last_nxt  = 1'b0;
            state_nxt = B_LOAD;
            for (int i = 0; i < 8; i++) chain_nxt[i] = init_hash(3'(i));
          end
        end
      end
      default: state_nxt = B_LOAD;
    endcase
  end

endmodule
